>>> rtl/core/kti_pkg.sv
// ----------------------------------------------------------------------------
// kti_pkg
// Shared types and codes of the keyframe track interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package kti_pkg;

  // input item kinds (tuser)
  localparam logic IN_LOAD  = 1'b0;
  localparam logic IN_QUERY = 1'b1;

  // configuration register indexes
  typedef logic [7:0] reg_idx_t;
  localparam reg_idx_t REG_KEY_COUNT  = 8'd0;
  localparam reg_idx_t REG_TRACK_KIND = 8'd1;

  // result status codes
  typedef logic [1:0] kstat_t;
  localparam kstat_t STAT_OK       = 2'd0;
  localparam kstat_t STAT_ZERO_LEN = 2'd1;
  localparam kstat_t STAT_SAT      = 2'd2;

  // step saturation and normalization window exponents
  localparam int STEP_LIM_LOG = 29;
  localparam int NORM_LO_LOG  = 29;
  localparam int NORM_HI_LOG  = 30;

  typedef struct packed {
    logic [31:0]      t;
    logic [3:0][31:0] c;
  } key_t;

  // datapath operations
  typedef logic [4:0] dp_op_t;
  localparam dp_op_t OP_NOP     = 5'd0;
  localparam dp_op_t OP_LOAD    = 5'd1;
  localparam dp_op_t OP_QSTART  = 5'd2;
  localparam dp_op_t OP_SRD     = 5'd3;
  localparam dp_op_t OP_SCMP    = 5'd4;
  localparam dp_op_t OP_RDA     = 5'd5;
  localparam dp_op_t OP_RDB     = 5'd6;
  localparam dp_op_t OP_CAPB    = 5'd7;
  localparam dp_op_t OP_DSTART  = 5'd8;
  localparam dp_op_t OP_STEP    = 5'd9;
  localparam dp_op_t OP_MUL     = 5'd10;
  localparam dp_op_t OP_ADD     = 5'd11;
  localparam dp_op_t OP_NCLR    = 5'd12;
  localparam dp_op_t OP_NORM    = 5'd13;
  localparam dp_op_t OP_SQ      = 5'd14;
  localparam dp_op_t OP_SACC    = 5'd15;
  localparam dp_op_t OP_RTINIT  = 5'd16;
  localparam dp_op_t OP_RT      = 5'd17;
  localparam dp_op_t OP_QDSTART = 5'd18;
  localparam dp_op_t OP_QCAP    = 5'd19;
  localparam dp_op_t OP_FIN     = 5'd20;
  localparam dp_op_t OP_RD0     = 5'd21;
  localparam dp_op_t OP_CAP0    = 5'd22;

  // result source select
  typedef logic [1:0] fin_sel_t;
  localparam fin_sel_t FIN_ONE  = 2'd0;
  localparam fin_sel_t FIN_VEC  = 2'd1;
  localparam fin_sel_t FIN_UNIT = 2'd2;
  localparam fin_sel_t FIN_QUAT = 2'd3;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] comp;
    fin_sel_t   sel;
  } dp_cmd_t;

  typedef struct packed {
    logic n_one;
    logic found;
    logic last;
    logic den_zero;
    logic div_busy;
    logic quat;
    logic m_zero;
    logic norm_done;
    logic rt_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/keyframe_track_interpolator_core.sv
// ----------------------------------------------------------------------------
// keyframe_track_interpolator_core
// Keyframe track store with linear and normalized quaternion interpolation.
// ----------------------------------------------------------------------------
// A load item writes one key. A query item is accepted, then the search reads
// and compares keys, the two keys of the segment are fetched, the serial step
// divider runs (skipped for a zero-length segment), the lerp runs and the
// result is presented once a previous result has been taken by out_tready. In
// quaternion mode the lerp is followed by a normalizing shift, a square sum, a
// square root and a division of each component. The single divider serves
// both divisions and the key store has one read port. A query with one key
// skips the search and returns key 0. The key store has no reset.
`default_nettype none

module keyframe_track_interpolator_core #(
  parameter int MAX_KEYS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // key_index, key_time, key_c0, key_c1, key_c2, key_c3, sample_time
  input  wire logic [199:0] in_tdata,
  // opcode
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_c0, out_c1, out_c2, out_c3, status
  output logic [135:0]      out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_index,
  input  wire logic [7:0]   cfg_data
);
  import kti_pkg::*;

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [3:0][31:0] key_c, out_c;
  kstat_t           out_status;

  assign key_c     = in_tdata[165:38];
  assign cfg_ready = 1'b1;
  assign out_tdata = {6'd0, out_status, out_c};

  kti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_opcode (in_tuser),
    .in_ready  (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  kti_dpath #(
    .MAX_KEYS  (MAX_KEYS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .key_index   (in_tdata[5:0]),
    .key_time    (in_tdata[37:6]),
    .key_c       (key_c),
    .sample_time (in_tdata[197:166]),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_c       (out_c),
    .out_status  (out_status)
  );

endmodule

`default_nettype wire

>>> rtl/core/kti_div.sv
// ----------------------------------------------------------------------------
// kti_div
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kti_div #(
  parameter int DW = 48
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [31:0]   divisor,
  output logic               busy,
  output logic [DW-1:0]      quot
);

  localparam int NW = $clog2(DW + 1);

  logic          busy_r;
  logic [NW-1:0] cnt_r;
  logic [32:0]   rem_r;
  logic [DW-1:0] quo_r;
  logic [31:0]   dvs_r;
  logic [32:0]   rem_t;
  logic          ge;

  assign rem_t = {rem_r[31:0], quo_r[DW-1]};
  assign ge    = rem_t >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= NW'(DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - NW'(1);
      if (cnt_r == NW'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? rem_t - {1'b0, dvs_r} : rem_t;
      quo_r <= {quo_r[DW-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quot = quo_r;

endmodule

`default_nettype wire

>>> rtl/core/kti_dpath.sv
// ----------------------------------------------------------------------------
// kti_dpath
// Key store, configuration, search, lerp, normalization and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kti_dpath #(
  parameter int MAX_KEYS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire kti_pkg::dp_cmd_t        cmd,
  output kti_pkg::dp_stat_t            stat,
  input  wire logic [5:0]              key_index,
  input  wire logic [31:0]             key_time,
  input  wire logic [3:0][31:0]        key_c,
  input  wire logic [31:0]             sample_time,
  input  wire logic                    cfg_we,
  input  wire kti_pkg::reg_idx_t       cfg_index,
  input  wire logic [7:0]              cfg_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [3:0][31:0]             out_c,
  output kti_pkg::kstat_t              out_status
);
  import kti_pkg::*;

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = (AW + 1 > 7) ? AW + 1 : 7;
  localparam int DW = 32 + FRAC_BITS;
  localparam logic [DW-1:0] STEP_LIM = DW'(64'd1 << STEP_LIM_LOG);
  localparam logic signed [63:0] S32_MAX = 64'sh7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN = -64'sh8000_0000;

  function automatic logic [32:0] sat32(input logic signed [63:0] x);
    logic [32:0] r;
    if (x > S32_MAX) r = {1'b1, 32'h7FFF_FFFF};
    else if (x < S32_MIN) r = {1'b1, 32'h8000_0000};
    else r = {1'b0, x[31:0]};
    return r;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  key_t mem [MAX_KEYS];
  key_t rd_r, a_r, b_r;
  logic [AW-1:0] rd_addr, idx_r, cur_r;

  logic [6:0]  kc_r;
  logic        kind_r;
  logic [31:0] sample_r;
  logic signed [30:0] step_r;
  logic        sat_r, zl_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] v_r [4];
  logic [63:0] m_r, acc_r, rn_r, res_r, bit_r;
  logic [31:0] qo_r [4];
  logic        out_valid_r;
  logic [3:0][31:0] out_c_r;
  kstat_t      out_st_r;

  logic [CW-1:0] kc_ext, n_eff;
  logic signed [32:0] num, den, num_abs, den_abs, mul_x, mul_y;
  logic signed [65:0] mul_p;
  logic [DW-1:0] div_dvd, quot;
  logic [31:0]   div_dvs;
  logic          div_start, div_busy;
  logic signed [63:0] vj, v_new;
  logic [63:0]   vj_mag, v_new_mag, rb;
  logic [30:0]   step_mag;
  logic          step_neg;
  logic [32:0]   qsat;
  logic signed [63:0] q_s;
  logic [3:0][32:0] vsat;
  logic          vec_ovf;
  kstat_t        flag_st;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kc_r   <= 7'd1;
      kind_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_KEY_COUNT) kc_r <= cfg_data[6:0];
      else if (cfg_index == REG_TRACK_KIND) kind_r <= cfg_data[0];
    end
  end

  assign kc_ext = CW'(kc_r);
  assign n_eff  = (kc_ext > CW'(MAX_KEYS)) ? CW'(MAX_KEYS) : kc_ext;

  // key store
  always_comb begin
    case (cmd.op)
      OP_SRD:  rd_addr = idx_r + AW'(1);
      OP_RDA:  rd_addr = cur_r;
      OP_RDB:  rd_addr = cur_r + AW'(1);
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && 32'(key_index) < 32'(MAX_KEYS))
      mem[AW'(key_index)] <= '{t: key_time, c: key_c};
    rd_r <= mem[rd_addr];
  end

  // arithmetic
  assign num     = $signed({1'b0, sample_r}) - $signed({1'b0, a_r.t});
  assign den     = $signed({1'b0, b_r.t}) - $signed({1'b0, a_r.t});
  assign num_abs = num[32] ? -num : num;
  assign den_abs = den[32] ? -den : den;

  assign vj     = v_r[cmd.comp];
  assign vj_mag = mag64(vj);

  always_comb begin
    if (cmd.op == OP_SQ) begin
      mul_x = vj[32:0];
      mul_y = vj[32:0];
    end else begin
      mul_x = $signed({b_r.c[cmd.comp][31], b_r.c[cmd.comp]})
            - $signed({a_r.c[cmd.comp][31], a_r.c[cmd.comp]});
      mul_y = {{2{step_r[30]}}, step_r};
    end
  end
  assign mul_p = mul_x * mul_y;

  assign v_new = $signed({{32{a_r.c[cmd.comp][31]}}, a_r.c[cmd.comp]})
               + (prod_r >>> FRAC_BITS);
  assign v_new_mag = mag64(v_new);

  always_comb begin
    if (cmd.op == OP_QDSTART) begin
      div_dvd = {vj_mag[31:0], {FRAC_BITS{1'b0}}};
      div_dvs = res_r[31:0];
    end else begin
      div_dvd = {num_abs[31:0], {FRAC_BITS{1'b0}}};
      div_dvs = den_abs[31:0];
    end
  end
  assign div_start = (cmd.op == OP_QDSTART) ||
                     (cmd.op == OP_DSTART && !stat.den_zero);

  kti_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quot     (quot)
  );

  assign step_neg = num[32] ^ den[32];
  assign step_mag = (quot > STEP_LIM) ? 31'(STEP_LIM) : quot[30:0];
  assign q_s      = vj[63] ? -$signed(64'(quot)) : $signed(64'(quot));
  assign qsat     = sat32(q_s);
  assign rb       = res_r + bit_r;

  always_comb begin
    vec_ovf = 1'b0;
    for (int i = 0; i < 4; i++) begin
      vsat[i] = sat32(v_r[i]);
      vec_ovf = vec_ovf | vsat[i][32];
    end
  end
  assign flag_st = sat_r ? STAT_SAT : (zl_r ? STAT_ZERO_LEN : STAT_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      cur_r <= '0;
    end else if (cmd.op == OP_QSTART) begin
      idx_r <= '0;
      cur_r <= '0;
    end else if (cmd.op == OP_SCMP) begin
      if (stat.found) cur_r <= idx_r;
      else if (!stat.last) idx_r <= idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_QSTART: begin
        sample_r <= sample_time;
        sat_r    <= 1'b0;
        zl_r     <= 1'b0;
        m_r      <= '0;
      end
      OP_RDB, OP_CAP0: a_r <= rd_r;
      OP_CAPB: b_r <= rd_r;
      OP_DSTART: begin
        if (stat.den_zero) begin
          step_r <= '0;
          zl_r   <= 1'b1;
        end
      end
      OP_STEP: begin
        step_r <= step_neg ? -$signed(step_mag) : $signed(step_mag);
        if (quot > STEP_LIM) sat_r <= 1'b1;
      end
      OP_MUL, OP_SQ: prod_r <= mul_p[63:0];
      OP_ADD: begin
        v_r[cmd.comp] <= v_new;
        if (v_new_mag > m_r) m_r <= v_new_mag;
      end
      OP_NCLR: acc_r <= '0;
      OP_NORM: begin
        if (m_r[63:NORM_HI_LOG] != '0) begin
          for (int i = 0; i < 4; i++) v_r[i] <= v_r[i] >>> 1;
          m_r <= m_r >> 1;
        end else begin
          for (int i = 0; i < 4; i++) v_r[i] <= v_r[i] <<< 1;
          m_r <= m_r << 1;
        end
      end
      OP_SACC: acc_r <= acc_r + prod_r;
      OP_RTINIT: begin
        rn_r  <= acc_r;
        res_r <= '0;
        bit_r <= 64'd1 << 62;
      end
      OP_RT: begin
        if (rn_r >= rb) begin
          rn_r  <= rn_r - rb;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_QCAP: begin
        qo_r[cmd.comp] <= qsat[31:0];
        if (qsat[32]) sat_r <= 1'b1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.op == OP_FIN) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FIN) begin
      case (cmd.sel)
        FIN_ONE: begin
          out_c_r  <= a_r.c;
          out_st_r <= STAT_OK;
        end
        FIN_VEC: begin
          for (int i = 0; i < 4; i++) out_c_r[i] <= vsat[i][31:0];
          out_st_r <= vec_ovf ? STAT_SAT : flag_st;
        end
        FIN_UNIT: begin
          out_c_r[0] <= 32'd1 << FRAC_BITS;
          out_c_r[1] <= '0;
          out_c_r[2] <= '0;
          out_c_r[3] <= '0;
          out_st_r   <= flag_st;
        end
        default: begin
          for (int i = 0; i < 4; i++) out_c_r[i] <= qo_r[i];
          out_st_r <= flag_st;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_c      = out_c_r;
  assign out_status = out_st_r;

  assign stat.n_one     = n_eff <= CW'(1);
  assign stat.found     = sample_r < rd_r.t;
  assign stat.last      = (CW'(idx_r) + CW'(2)) >= n_eff;
  assign stat.den_zero  = den == '0;
  assign stat.div_busy  = div_busy;
  assign stat.quat      = kind_r;
  assign stat.m_zero    = m_r == '0;
  assign stat.norm_done = (m_r[63:NORM_HI_LOG] == '0) && m_r[NORM_LO_LOG];
  assign stat.rt_done   = bit_r == '0;
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule

`default_nettype wire

>>> rtl/core/kti_ctrl.sv
// ----------------------------------------------------------------------------
// kti_ctrl
// Sequencer of one query: search, step division, lerp, normalization.
// ----------------------------------------------------------------------------
`default_nettype none

module kti_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_opcode,
  output logic                   in_ready,
  input  wire kti_pkg::dp_stat_t stat,
  output kti_pkg::dp_cmd_t       cmd
);
  import kti_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_ONE_RD  = 5'd1;
  localparam logic [4:0] S_ONE_CAP = 5'd2;
  localparam logic [4:0] S_SRD     = 5'd3;
  localparam logic [4:0] S_SCMP    = 5'd4;
  localparam logic [4:0] S_RDA     = 5'd5;
  localparam logic [4:0] S_RDB     = 5'd6;
  localparam logic [4:0] S_CAPB    = 5'd7;
  localparam logic [4:0] S_DSTART  = 5'd8;
  localparam logic [4:0] S_DWAIT   = 5'd9;
  localparam logic [4:0] S_MUL     = 5'd10;
  localparam logic [4:0] S_ADD     = 5'd11;
  localparam logic [4:0] S_NCHK    = 5'd12;
  localparam logic [4:0] S_NORM    = 5'd13;
  localparam logic [4:0] S_SQ      = 5'd14;
  localparam logic [4:0] S_SACC    = 5'd15;
  localparam logic [4:0] S_RTINIT  = 5'd16;
  localparam logic [4:0] S_RT      = 5'd17;
  localparam logic [4:0] S_QDIV    = 5'd18;
  localparam logic [4:0] S_QWAIT   = 5'd19;
  localparam logic [4:0] S_FIN     = 5'd20;

  logic [4:0] state_r, state_nxt;
  logic [1:0] j_r, j_nxt;
  fin_sel_t   fsel_r, fsel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      j_r     <= '0;
      fsel_r  <= FIN_ONE;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      fsel_r  <= fsel_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    fsel_nxt  = fsel_r;
    cmd.op    = OP_NOP;
    cmd.comp  = j_r;
    cmd.sel   = fsel_r;
    in_ready  = state_r == S_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == IN_LOAD) begin
            cmd.op = OP_LOAD;
          end else begin
            cmd.op    = OP_QSTART;
            state_nxt = stat.n_one ? S_ONE_RD : S_SRD;
          end
        end
      end
      S_ONE_RD: begin
        cmd.op    = OP_RD0;
        state_nxt = S_ONE_CAP;
      end
      S_ONE_CAP: begin
        cmd.op    = OP_CAP0;
        fsel_nxt  = FIN_ONE;
        state_nxt = S_FIN;
      end
      S_SRD: begin
        cmd.op    = OP_SRD;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        cmd.op    = OP_SCMP;
        state_nxt = (stat.found || stat.last) ? S_RDA : S_SRD;
      end
      S_RDA: begin
        cmd.op    = OP_RDA;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        cmd.op    = OP_RDB;
        state_nxt = S_CAPB;
      end
      S_CAPB: begin
        cmd.op    = OP_CAPB;
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        cmd.op    = OP_DSTART;
        j_nxt     = '0;
        state_nxt = stat.den_zero ? S_MUL : S_DWAIT;
      end
      S_DWAIT: begin
        if (!stat.div_busy) begin
          cmd.op    = OP_STEP;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.op = OP_ADD;
        if (j_r == 2'd3) begin
          if (stat.quat) begin
            state_nxt = S_NCHK;
          end else begin
            fsel_nxt  = FIN_VEC;
            state_nxt = S_FIN;
          end
        end else begin
          j_nxt     = j_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_NCHK: begin
        cmd.op = OP_NCLR;
        j_nxt  = '0;
        if (stat.m_zero) begin
          fsel_nxt  = FIN_UNIT;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (stat.norm_done) state_nxt = S_SQ;
        else cmd.op = OP_NORM;
      end
      S_SQ: begin
        cmd.op    = OP_SQ;
        state_nxt = S_SACC;
      end
      S_SACC: begin
        cmd.op = OP_SACC;
        if (j_r == 2'd3) begin
          state_nxt = S_RTINIT;
        end else begin
          j_nxt     = j_r + 2'd1;
          state_nxt = S_SQ;
        end
      end
      S_RTINIT: begin
        cmd.op    = OP_RTINIT;
        state_nxt = S_RT;
      end
      S_RT: begin
        if (stat.rt_done) begin
          j_nxt     = '0;
          state_nxt = S_QDIV;
        end else begin
          cmd.op = OP_RT;
        end
      end
      S_QDIV: begin
        cmd.op    = OP_QDSTART;
        state_nxt = S_QWAIT;
      end
      S_QWAIT: begin
        if (!stat.div_busy) begin
          cmd.op = OP_QCAP;
          if (j_r == 2'd3) begin
            fsel_nxt  = FIN_QUAT;
            state_nxt = S_FIN;
          end else begin
            j_nxt     = j_r + 2'd1;
            state_nxt = S_QDIV;
          end
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.op    = OP_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/kti_chk.sv
// ----------------------------------------------------------------------------
// kti_chk
// Port-level checks of the keyframe track interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

module kti_chk (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         in_tuser,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [135:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[129:128] != 2'b11)
    else $error("undefined status code");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !out_tvalid |=> !out_tvalid)
    else $error("load produced a result");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("query accepted without going busy");

endmodule

bind keyframe_track_interpolator_core kti_chk u_kti_chk (.*);

`default_nettype wire
